/* rtl/agn_pkg.sv */
// Shared types, constants and arithmetic helpers of the animated gradient noise block.
package agn_pkg;

   localparam int GRID_COLS = 64;
   localparam int GRID_ROWS = 64;
   localparam int FRAC_BITS = 16;
   localparam int COL_BITS  = $clog2(GRID_COLS);
   localparam int ROW_BITS  = $clog2(GRID_ROWS);
   localparam int ADDR_BITS = COL_BITS + ROW_BITS;
   localparam int CELLS     = GRID_COLS * GRID_ROWS;
   localparam int Q_W       = 20;
   localparam int CELL_W    = 2 * Q_W;
   localparam int PT_W      = 22;
   localparam int OFF_W     = FRAC_BITS + 2;
   localparam int DOT_W     = 24;
   localparam int OPA_W     = DOT_W + 1;
   localparam int PROD_W    = OPA_W + Q_W;
   localparam int ACC_W     = PROD_W + 1;
   localparam int SAT_IN_W  = DOT_W + 2;
   localparam int QUO_W     = 11;
   localparam int IDX_W     = 4;

   localparam logic [IDX_W-1:0] IDX_TOP  = 4'd8;
   localparam logic [IDX_W-1:0] IDX_BOT  = 4'd9;
   localparam logic [IDX_W-1:0] IDX_LAST = 4'd10;

   localparam logic signed [Q_W-1:0] Q_MAX = 20'sd524287;
   localparam logic signed [Q_W-1:0] Q_MIN = -20'sd524288;
   localparam logic signed [Q_W-1:0] Q_ONE = 20'sd65536;

   // Reciprocal of 1000 scaled by 2^30, rounded up; exact for dividends below 2^22.
   localparam int          RECIP_SHIFT = 30;
   localparam logic [20:0] RECIP_1000  = 21'd1073742;
   localparam logic [19:0] HALF_1000   = 20'd500;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EVAL = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GET_TL,
      ST_GET_TR,
      ST_GET_BL,
      ST_GET_BR,
      ST_MUL,
      ST_ACC,
      ST_DIV_X,
      ST_DIV_Y,
      ST_WB
   } state_type;

   typedef struct packed {
      op_type                 operation;
      logic [5:0]             cell_col;
      logic [5:0]             cell_row;
      logic signed [Q_W-1:0]  grad_x;
      logic signed [Q_W-1:0]  grad_y;
      logic signed [Q_W-1:0]  drift_x;
      logic signed [Q_W-1:0]  drift_y;
      logic [PT_W-1:0]        point_x;
      logic [PT_W-1:0]        point_y;
   } req_word_type;

   typedef struct packed {
      logic signed [Q_W-1:0] noise_value;
   } rsp_word_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] rd_addr;
      logic [ADDR_BITS-1:0] wr_addr;
      logic                 g_we;
      logic                 d_we;
      logic [CELL_W-1:0]    g_wdata;
      logic [CELL_W-1:0]    d_wdata;
   } mem_req_type;

   function automatic logic signed [Q_W-1:0] sat20(input logic signed [SAT_IN_W-1:0] v);
      logic signed [SAT_IN_W-1:0] hi;
      logic signed [SAT_IN_W-1:0] lo;
      hi = SAT_IN_W'(Q_MAX);
      lo = SAT_IN_W'(Q_MIN);
      if (v > hi) return Q_MAX;
      if (v < lo) return Q_MIN;
      return v[Q_W-1:0];
   endfunction

   // Round half away from zero of d / 1000.
   function automatic logic signed [QUO_W-1:0] div1000(input logic signed [Q_W-1:0] d);
      logic [Q_W-1:0]  mag;
      logic [Q_W-1:0]  num;
      logic [41:0]     prod;
      logic [QUO_W-1:0] q;
      mag  = d[Q_W-1] ? Q_W'(-d) : d;
      num  = mag + HALF_1000;
      prod = 42'(num) * 42'(RECIP_1000);
      q    = prod[RECIP_SHIFT +: QUO_W];
      return d[Q_W-1] ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic signed [Q_W-1:0] neg_sat(input logic signed [Q_W-1:0] d);
      return (d == Q_MIN) ? Q_MAX : -d;
   endfunction

endpackage

/* rtl/agn_intf.sv */
// Valid/ready channel interfaces for request and response words.
interface agn_req_if;
   import agn_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface agn_rsp_if;
   import agn_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/agn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module agn_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/agn_core.sv */
// Sequencer and datapath: corner reads, shared multiplier, drift update and write-back.
module agn_core (
   input  logic                          clock,
   input  logic                          reset,
   agn_req_if.sink                       req_port,
   output agn_pkg::mem_req_type          mem_req,
   input  logic [agn_pkg::CELL_W-1:0]    g_rdata,
   input  logic [agn_pkg::CELL_W-1:0]    d_rdata,
   input  logic                          slot_free,
   output logic                          res_valid,
   output logic signed [agn_pkg::Q_W-1:0] res_value
);
   import agn_pkg::*;

   state_type                  state_ff, state_in;
   logic [COL_BITS-1:0]        c0_ff;
   logic [ROW_BITS-1:0]        r0_ff;
   logic [FRAC_BITS-1:0]       fx_ff, fy_ff;
   logic [CELL_W-1:0]          corner_ff [4];
   logic [CELL_W-1:0]          drift_ff;
   logic [IDX_W-1:0]           idx_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [DOT_W-1:0]    dot_ff [4];
   logic signed [DOT_W-1:0]    top_ff, bot_ff;
   logic signed [Q_W-1:0]      res_ff, gx_new_ff, gy_new_ff;

   logic [1:0]                 k;
   logic signed [OFF_W-1:0]    off;
   logic signed [Q_W-1:0]      grad;
   logic signed [DOT_W-1:0]    base, other;
   logic [FRAC_BITS-1:0]       t;
   logic signed [OPA_W-1:0]    opa;
   logic signed [Q_W-1:0]      opb;
   logic signed [ACC_W-1:0]    dot_sum;
   logic signed [ACC_W-1:0]    lerp_rnd;
   logic signed [DOT_W-1:0]    dot_val, lerp_val;
   logic signed [QUO_W-1:0]    quo;
   logic signed [Q_W-1:0]      g_old;
   logic signed [Q_W-1:0]      g_new;
   logic                       outside;
   logic                       accept;

   assign accept = req_port.valid && req_port.ready;

   // Multiplier operand selection.
   always_comb begin
      k     = idx_ff[2:1];
      off   = (k[idx_ff[0]] ? OFF_W'(1 << FRAC_BITS) : '0)
              - $signed({2'b00, idx_ff[0] ? fy_ff : fx_ff});
      grad  = idx_ff[0] ? corner_ff[k][Q_W-1:0] : corner_ff[k][CELL_W-1:Q_W];
      priority case (idx_ff)
         IDX_TOP: begin
            base = dot_ff[0]; other = dot_ff[1]; t = fx_ff;
         end
         IDX_BOT: begin
            base = dot_ff[2]; other = dot_ff[3]; t = fx_ff;
         end
         default: begin
            base = top_ff; other = bot_ff; t = fy_ff;
         end
      endcase
      if (idx_ff < IDX_TOP) begin
         opa = OPA_W'(off);
         opb = grad;
      end else begin
         opa = OPA_W'(other) - OPA_W'(base);
         opb = $signed({{(Q_W-FRAC_BITS){1'b0}}, t});
      end
   end

   // Rounding of accumulated products back to Q.16.
   always_comb begin
      dot_sum  = acc_ff + ACC_W'(prod_ff) + ACC_W'(1 << (FRAC_BITS-1));
      dot_sum  = dot_sum >>> FRAC_BITS;
      dot_val  = dot_sum[DOT_W-1:0];
      lerp_rnd = ACC_W'(prod_ff) + ACC_W'(1 << (FRAC_BITS-1));
      lerp_rnd = lerp_rnd >>> FRAC_BITS;
      lerp_val = base + lerp_rnd[DOT_W-1:0];
   end

   // Drift step for one component.
   always_comb begin
      quo   = div1000((state_ff == ST_DIV_Y) ? drift_ff[Q_W-1:0] : drift_ff[CELL_W-1:Q_W]);
      g_old = (state_ff == ST_DIV_Y) ? corner_ff[0][Q_W-1:0] : corner_ff[0][CELL_W-1:Q_W];
      g_new = sat20(SAT_IN_W'(g_old) - SAT_IN_W'(quo));
      outside = (gx_new_ff > Q_ONE) || (gx_new_ff < -Q_ONE)
                || (gy_new_ff > Q_ONE) || (gy_new_ff < -Q_ONE);
   end

   // Next state and memory requests.
   always_comb begin
      state_in        = state_ff;
      req_port.ready  = (state_ff == ST_IDLE);
      res_valid       = (state_ff == ST_WB);
      mem_req.rd_addr = {r0_ff, c0_ff};
      mem_req.wr_addr = {r0_ff, c0_ff};
      mem_req.g_we    = 1'b0;
      mem_req.d_we    = 1'b0;
      mem_req.g_wdata = {gx_new_ff, gy_new_ff};
      mem_req.d_wdata = {neg_sat(drift_ff[CELL_W-1:Q_W]), neg_sat(drift_ff[Q_W-1:0])};
      unique case (state_ff)
         ST_IDLE: begin
            mem_req.rd_addr = {req_port.data.point_y[FRAC_BITS +: ROW_BITS],
                               req_port.data.point_x[FRAC_BITS +: COL_BITS]};
            mem_req.wr_addr = {req_port.data.cell_row[ROW_BITS-1:0],
                               req_port.data.cell_col[COL_BITS-1:0]};
            mem_req.g_wdata = {req_port.data.grad_x, req_port.data.grad_y};
            mem_req.d_wdata = {req_port.data.drift_x, req_port.data.drift_y};
            if (accept) begin
               if (req_port.data.operation == OP_LOAD) begin
                  mem_req.g_we = 1'b1;
                  mem_req.d_we = 1'b1;
               end else begin
                  state_in = ST_GET_TL;
               end
            end
         end
         ST_GET_TL: begin
            mem_req.rd_addr = {r0_ff, COL_BITS'(c0_ff + 1'b1)};
            state_in = ST_GET_TR;
         end
         ST_GET_TR: begin
            mem_req.rd_addr = {ROW_BITS'(r0_ff + 1'b1), c0_ff};
            state_in = ST_GET_BL;
         end
         ST_GET_BL: begin
            mem_req.rd_addr = {ROW_BITS'(r0_ff + 1'b1), COL_BITS'(c0_ff + 1'b1)};
            state_in = ST_GET_BR;
         end
         ST_GET_BR: state_in = ST_MUL;
         ST_MUL:    state_in = ST_ACC;
         ST_ACC:    state_in = (idx_ff == IDX_LAST) ? ST_DIV_X : ST_MUL;
         ST_DIV_X:  state_in = ST_DIV_Y;
         ST_DIV_Y:  state_in = ST_WB;
         ST_WB: begin
            if (slot_free) begin
               mem_req.g_we = 1'b1;
               mem_req.d_we = outside;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         c0_ff  <= req_port.data.point_x[FRAC_BITS +: COL_BITS];
         r0_ff  <= req_port.data.point_y[FRAC_BITS +: ROW_BITS];
         fx_ff  <= req_port.data.point_x[FRAC_BITS-1:0];
         fy_ff  <= req_port.data.point_y[FRAC_BITS-1:0];
         idx_ff <= '0;
      end
      if (state_ff == ST_GET_TL) begin
         corner_ff[0] <= g_rdata;
         drift_ff     <= d_rdata;
      end
      if (state_ff == ST_GET_TR) corner_ff[1] <= g_rdata;
      if (state_ff == ST_GET_BL) corner_ff[2] <= g_rdata;
      if (state_ff == ST_GET_BR) corner_ff[3] <= g_rdata;
      if (state_ff == ST_MUL) begin
         prod_ff <= PROD_W'(opa) * PROD_W'(opb);
      end
      if (state_ff == ST_ACC) begin
         idx_ff <= idx_ff + 1'b1;
         if (idx_ff < IDX_TOP) begin
            if (!idx_ff[0]) begin
               acc_ff <= ACC_W'(prod_ff);
            end else begin
               dot_ff[idx_ff[2:1]] <= dot_val;
               acc_ff <= '0;
            end
         end else if (idx_ff == IDX_TOP) begin
            top_ff <= lerp_val;
         end else if (idx_ff == IDX_BOT) begin
            bot_ff <= lerp_val;
         end else begin
            res_ff <= sat20(SAT_IN_W'(lerp_val));
         end
      end
      if (state_ff == ST_IDLE) acc_ff <= '0;
      if (state_ff == ST_DIV_X) gx_new_ff <= g_new;
      if (state_ff == ST_DIV_Y) gy_new_ff <= g_new;
   end

   assign res_value = res_ff;
endmodule

/* rtl/animated_gradient_noise_2d.sv */
// Top level of the animated 2D gradient noise block: memories, core and response register.
//
//   channel   dir  handshake                 word
//   req_port  in   valid/ready               operation, cell, gradient, drift, point
//   rsp_port  out  valid/ready               noise_value
//
// A load word writes both memories at the accept edge.
// An evaluate word presents its response after four corner reads, 11
// multiply/accumulate passes through one shared multiplier (eight dot-product
// terms, three blends), two drift steps and the write-back, plus any wait for
// the response register to drain; the next word is taken once the block is idle again.
// Reset clears only control; both memories are undefined until loaded.
module animated_gradient_noise_2d (
   input logic        clock,
   input logic        reset,
   agn_req_if.sink    req_port,
   agn_rsp_if.source  rsp_port
);
   import agn_pkg::*;

   mem_req_type           mem_req;
   logic [CELL_W-1:0]     g_rdata;
   logic [CELL_W-1:0]     d_rdata;
   logic                  slot_free;
   logic                  res_valid;
   logic signed [Q_W-1:0] res_value;
   logic                  rsp_valid_ff;
   logic signed [Q_W-1:0] rsp_value_ff;

   // Gradient memory: {grad_x, grad_y} per cell.
   agn_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_grad_ram (
      .clock   (clock),
      .we      (mem_req.g_we),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.g_wdata),
      .rd_addr (mem_req.rd_addr),
      .rd_data (g_rdata)
   );

   // Drift memory: {drift_x, drift_y} per cell.
   agn_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_drift_ram (
      .clock   (clock),
      .we      (mem_req.d_we),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.d_wdata),
      .rd_addr (mem_req.rd_addr),
      .rd_data (d_rdata)
   );

   agn_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_port),
      .mem_req   (mem_req),
      .g_rdata   (g_rdata),
      .d_rdata   (d_rdata),
      .slot_free (slot_free),
      .res_valid (res_valid),
      .res_value (res_value)
   );

   // Response register: free when empty or draining this cycle.
   assign slot_free = !rsp_valid_ff || rsp_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && slot_free) begin
         rsp_value_ff <= res_value;
      end
   end

   assign rsp_port.valid            = rsp_valid_ff;
   assign rsp_port.data.noise_value = rsp_value_ff;

`ifndef SYNTH
   // An evaluate word holds the block busy on the next cycle.
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready && req_port.data.operation == OP_EVAL)
      |=> !req_port.ready)
      else $error("request taken right after an evaluate word");

   // A load word leaves the block ready again on the next cycle.
   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready && req_port.data.operation == OP_LOAD)
      |=> req_port.ready)
      else $error("load word did not complete in one cycle");

   // A new response is only launched from write-back, never while idle.
   a_rsp_from_wb: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_port.valid) |-> $past(!req_port.ready))
      else $error("response appeared without an evaluate in flight");
`endif
endmodule

/* tb/animated_gradient_noise_2d_tb.sv */
// Self-checking testbench of the animated 2D gradient noise block.
module animated_gradient_noise_2d_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import agn_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 64;
   localparam int RANDOM_WORDS   = 1300;
   localparam int WIN_BASE       = 60;
   localparam int WIN_SIZE       = 16;
   localparam int REQ_W          = $bits(req_word_type);

   // Noise scoreboard: keeps its own copy of both grids, predicts each noise
   // value on acceptance and compares response words against them in order.
   class noise_scoreboard;
      longint grad[CELLS][2];
      longint drift[CELLS][2];
      logic signed [Q_W-1:0] noise_q[$];
      int mismatches;
      int loads_seen;
      int evals_seen;
      int checked;
      int flips;

      function longint round_q16(longint v);
         return (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      endfunction

      function longint clamp20(longint v);
         if (v > Q_MAX) return longint'(Q_MAX);
         if (v < Q_MIN) return longint'(Q_MIN);
         return v;
      endfunction

      function longint step_1000(longint d);
         if (d >= 0) return (d + 500) / 1000;
         return -((-d + 500) / 1000);
      endfunction

      function longint corner_dot(int idx, longint dx, longint dy);
         return round_q16(dx * grad[idx][0] + dy * grad[idx][1]);
      endfunction

      function longint lerp(longint a, longint b, longint t);
         return a + round_q16((b - a) * t);
      endfunction

      function void note_input(req_word_type w);
         int tl, tr, bl, br;
         logic [COL_BITS-1:0] c0, c1;
         logic [ROW_BITS-1:0] r0, r1;
         longint fx, fy, one, top, bot, g;
         bit outside;
         if (w.operation == OP_LOAD) begin
            tl = int'({w.cell_row, w.cell_col});
            grad[tl][0]  = longint'(w.grad_x);
            grad[tl][1]  = longint'(w.grad_y);
            drift[tl][0] = longint'(w.drift_x);
            drift[tl][1] = longint'(w.drift_y);
            loads_seen++;
            return;
         end
         evals_seen++;
         one = longint'(1) << FRAC_BITS;
         fx = longint'(w.point_x[FRAC_BITS-1:0]);
         fy = longint'(w.point_y[FRAC_BITS-1:0]);
         c0 = w.point_x[FRAC_BITS +: COL_BITS];
         r0 = w.point_y[FRAC_BITS +: ROW_BITS];
         // corners past the edge wrap around
         c1 = c0 + 1'b1;
         r1 = r0 + 1'b1;
         tl = int'({r0, c0});
         tr = int'({r0, c1});
         bl = int'({r1, c0});
         br = int'({r1, c1});
         top = lerp(corner_dot(tl, -fx, -fy), corner_dot(tr, one - fx, -fy), fx);
         bot = lerp(corner_dot(bl, -fx, one - fy), corner_dot(br, one - fx, one - fy), fx);
         noise_q.push_back(Q_W'(clamp20(lerp(top, bot, fy))));
         // animate the top-left gradient after the sample is taken
         outside = 0;
         for (int k = 0; k < 2; k++) begin
            g = clamp20(grad[tl][k] - step_1000(drift[tl][k]));
            grad[tl][k] = g;
            if (g > Q_ONE || g < -Q_ONE) outside = 1;
         end
         if (outside) begin
            flips++;
            for (int k = 0; k < 2; k++)
               drift[tl][k] = (drift[tl][k] == Q_MIN) ? longint'(Q_MAX) : -drift[tl][k];
         end
      endfunction

      function void check_result(rsp_word_type r);
         logic signed [Q_W-1:0] want;
         if (noise_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected response word noise_value=%0d", r.noise_value);
            return;
         end
         want = noise_q.pop_front();
         checked++;
         if (r.noise_value !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: noise_value mismatch: expected %0d, got %0d",
                        want, r.noise_value);
         end
      endfunction

      function int pending();
         return noise_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   agn_req_if req_if ();
   agn_rsp_if rsp_if ();

   animated_gradient_noise_2d u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if.sink),
      .rsp_port (rsp_if.source)
   );

   noise_scoreboard sb;
   int send_idle_pct;
   int recv_stall_pct;
   int quiet_cycles;
   bit stim_done;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver: stall at random by the current percentage.
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor both channels and run the watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) sb.note_input(req_if.data);
         if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Hold valid until the word is taken; idle first at random.
   task automatic send_word(req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         req_if.data  <= req_word_type'(REQ_W'({$urandom, $urandom, $urandom, $urandom,
                                                 $urandom}));
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= w;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Drop valid and wait until every noise value has come back.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic req_word_type load_word(int col, int row, longint gx, longint gy,
                                              longint dx, longint dy);
      req_word_type w;
      w = req_word_type'(REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      w.operation = OP_LOAD;
      w.cell_col  = 6'(col);
      w.cell_row  = 6'(row);
      w.grad_x    = Q_W'(gx);
      w.grad_y    = Q_W'(gy);
      w.drift_x   = Q_W'(dx);
      w.drift_y   = Q_W'(dy);
      return w;
   endfunction

   function automatic req_word_type eval_word(logic [PT_W-1:0] px, logic [PT_W-1:0] py);
      req_word_type w;
      w = req_word_type'(REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      w.operation = OP_EVAL;
      w.point_x   = px;
      w.point_y   = py;
      return w;
   endfunction

   // Gradient component: mostly inside [-1,1], some near the bound, some anywhere.
   function automatic longint rand_grad();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) return longint'($urandom_range(131072)) - 65536;
      if (pick < 85) return ($urandom_range(1) ? 1 : -1) * longint'($urandom_range(66536, 64536));
      return longint'($urandom_range(1048575)) - 524288;
   endfunction

   // Drift component: mostly modest so gradients walk gradually toward the bound.
   function automatic longint rand_drift();
      int pick;
      pick = $urandom_range(99);
      if (pick < 75) return longint'($urandom_range(400000)) - 200000;
      if (pick < 85) return ($urandom_range(1) ? 500 : -500) + 1000 * longint'($urandom_range(20)) - 10000;
      return longint'($urandom_range(1048575)) - 524288;
   endfunction

   // Points: half land on a few hot cells around the wrap corner so drift keeps
   // hitting the same gradients, the rest anywhere inside the loaded window.
   function automatic logic [PT_W-1:0] rand_point();
      logic [PT_W-1:0] p;
      p = PT_W'($urandom);
      if ($urandom_range(1)) p[FRAC_BITS +: 6] = 6'(62 + $urandom_range(3));
      else p[FRAC_BITS +: 6] = 6'(WIN_BASE + $urandom_range(WIN_SIZE - 2));
      return p;
   endfunction

   initial begin
      sb = new();
      clock          = 1'b0;
      reset          = 1'b1;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      quiet_cycles   = 0;
      stim_done      = 0;
      req_if.valid   = 1'b0;
      req_if.data    = '0;
      rsp_if.ready   = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the sampled window, which wraps across the grid corner, so that
      // no evaluate ever reads an unwritten entry.
      for (int i = 0; i < WIN_SIZE; i++)
         for (int j = 0; j < WIN_SIZE; j++)
            send_word(load_word((WIN_BASE + j) % GRID_COLS, (WIN_BASE + i) % GRID_ROWS,
                                rand_grad(), rand_grad(), rand_drift(), rand_drift()));

      // Directed: field extremes, rounding ties, wrap at the far corner,
      // saturating drift negation, and a sample taken before its own drift step.
      send_word(load_word(63, 63, Q_MAX, Q_MIN, Q_MIN, Q_MAX));
      send_word(load_word(0, 0, Q_MIN, Q_MAX, 500, -500));
      send_word(load_word(0, 63, 65536, -65536, 1500, -1500));
      send_word(load_word(63, 0, 0, 0, 499, -501));
      send_word(eval_word('1, '1));
      send_word(eval_word(22'h3F0000, 22'h3F0000));
      send_word(eval_word(22'h3F0000, 22'h3F0000));
      send_word(eval_word('0, '0));
      send_word(eval_word('0, '0));
      send_word(eval_word(22'h008000, 22'h008000));
      send_word(eval_word(22'h3F8000, 22'h000001));
      send_word(eval_word(22'h00FFFF, 22'h3FFFFF));
      send_word(load_word(1, 1, 65536, 65536, -1, 1));
      send_word(eval_word(22'h010000, 22'h010000));
      send_word(eval_word(22'h010000, 22'h010000));
      send_word(eval_word(22'h0AAAAA, 22'h055555));
      send_word(eval_word(22'h055555, 22'h0AAAAA));
      drain();

      // Random words across four idling phases; pause for a full drain between.
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 57 : 27) : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 57 : 27) : 0;
         for (int n = 0; n < RANDOM_WORDS / 4; n++) begin
            if ($urandom_range(99) < 25)
               send_word(load_word($urandom_range(63), $urandom_range(63), rand_grad(),
                                   rand_grad(), rand_drift(), rand_drift()));
            else
               send_word(eval_word(rand_point(), rand_point()));
         end
         drain();
      end
      stim_done = 1;
   end

   // Finish once all stimulus has drained, or on a stuck channel.
   initial begin
      wait (reset == 1'b0);
      while (!stim_done && quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      if (!stim_done) begin
         $display("ERROR: no handshake for %0d cycles, %0d noise values outstanding",
                  WATCHDOG_LIMIT, sb.pending());
         $display("animated_gradient_noise_2d verification failed");
         $finish;
      end
      $display("Covered %0d loads and %0d evaluates, %0d noise values compared,",
               sb.loads_seen, sb.evals_seen, sb.checked);
      $display("%0d drift reversals, %0d mismatches.", sb.flips, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("animated_gradient_noise_2d verification clean");
      end else begin
         $display("animated_gradient_noise_2d verification failed");
      end
      $finish;
   end

endmodule
